// ===== design/assert_macros.svh =====
// Assertion helpers included by the solver unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tdma_pkg.sv =====
package tdma_pkg;
    localparam int MAX_CELLS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int W = 32;
    localparam logic signed [W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    // Saturate a 66 bit signed value to 32 bits; flag reports clipping.
    function automatic logic [W:0] sat32(input logic signed [65:0] v);
        logic [W:0] r;
        if (v > 66'(signed'(S32_MAX))) r = {1'b1, S32_MAX};
        else if (v < 66'(signed'(S32_MIN))) r = {1'b1, S32_MIN};
        else r = {1'b0, v[W-1:0]};
        return r;
    endfunction
endpackage

// ===== design/tridiagonal_thomas_solver_unit.sv =====
// Channel | dir | tdata fields (low bit first)                      | tuser / tlast
// s_axis  | in  | west_coef, east_coef, centre_extra, source_term,   | tlast = last_cell
//         |     | east_boundary (160 bits)                           |
// m_axis  | out | cell_value (32 bits)                               | tuser = cell_number,
//         |     |                                                    | singular; tlast = run_end
// After a transfer on s_axis, unless the store is already full, the input stays not ready
// while the shared bit-serial divider (Q16.16 by default) forms ratio and then offset.
// On the last cell the backward sweep runs ST_BRD, ST_BMUL and ST_BADD per stored cell
// (after ST_WR when the store was already full), writing each solved value over its offset entry.
// Only then is the singular flag final, so the results are emitted in a second pass
// via ST_ERD and ST_OUT, held by any m_axis_tready stall; the input is not ready meanwhile.
// Reset is synchronous and active low; the coefficient memories are not cleared.
module tridiagonal_thomas_solver_unit
    import tdma_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,   // west, east, centre_extra, source, east_boundary
    input  logic         s_axis_tlast,   // last_cell
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // cell_value
    output logic [7:0]   m_axis_tuser,   // cell_number[6:0], singular
    output logic         m_axis_tlast    // run_end
);
`include "assert_macros.svh"
    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = $clog2(MAX_CELLS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0, ST_DIAG = 4'd1, ST_MUL = 4'd2, ST_DEN = 4'd3,
        ST_DR = 4'd4, ST_DO = 4'd5, ST_STORE = 4'd6, ST_BRD = 4'd7, ST_BMUL = 4'd8,
        ST_BADD = 4'd9, ST_OUT = 4'd10, ST_WR = 4'd11, ST_ERD = 4'd12;

    logic [3:0] r_st;
    logic signed [W-1:0] r_w, r_e, r_c, r_s, r_x, r_acc, r_num, r_den, r_ratio;
    logic signed [W-1:0] r_prev_r, r_prev_o, r_rd_r, r_rd_o;
    logic r_last, r_sing, r_mphase;
    logic [CW-1:0] r_cnt, r_idx;
    logic signed [W-1:0] ratio_mem [MAX_CELLS];
    logic signed [W-1:0] offset_mem [MAX_CELLS];
    logic signed [W-1:0] r_ma, r_mb;
    logic signed [63:0] r_prod;
    logic signed [65:0] w_floor;
    t_div_ctl w_dctl;
    logic w_ddone, w_dsat;
    logic signed [W-1:0] w_quo, w_out_num;
    logic [W:0] w_sa, w_sb, w_sd;

    // Shared multiplier, registered; floor scaling by arithmetic shift.
    always_ff @(posedge i_clk) r_prod <= r_ma * r_mb;
    assign w_floor = 66'(r_prod) >>> FRAC_BITS;

    assign w_dctl.start = (r_st == ST_DEN) || (r_st == ST_DR && w_ddone);
    assign w_dctl.busy = (r_st == ST_DR) || (r_st == ST_DO);
    assign w_out_num = (r_st == ST_DEN) ? r_e : r_num;

    tdma_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl),
        .i_num(w_dctl.busy ? r_num : w_out_num), .i_den(r_den),
        .o_done(w_ddone), .o_quo(w_quo), .o_sat(w_dsat)
    );

    assign w_sa = sat32(66'(r_c) + 66'(r_w) + 66'(r_e));
    assign w_sb = sat32(w_floor + 66'(r_acc));
    assign w_sd = sat32(66'(r_acc) - w_floor);

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata = r_rd_o;
    assign m_axis_tuser = {r_sing, 7'(r_idx) + 7'd1};
    assign m_axis_tlast = (r_idx == '0);

    // The backward sweep overwrites each offset entry with the solved value of its cell.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_STORE) begin
            ratio_mem[r_cnt[AW-1:0]] <= r_ratio;
            offset_mem[r_cnt[AW-1:0]] <= r_num;
        end else if (r_st == ST_BADD && r_mphase) begin
            offset_mem[r_idx[AW-1:0]] <= w_sb[W-1:0];
        end
        r_rd_r <= ratio_mem[r_idx[AW-1:0]];
        r_rd_o <= offset_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_cnt <= '0; r_sing <= 1'b0;
            r_prev_r <= '0; r_prev_o <= '0; r_idx <= '0; r_mphase <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: if (s_axis_tvalid) begin
                    {r_x, r_s, r_c, r_e, r_w} <= s_axis_tdata;
                    r_last <= s_axis_tlast;
                    // Start w * prev ratio right away.
                    r_ma <= s_axis_tdata[W-1:0]; r_mb <= r_prev_r;
                    if (r_cnt == CW'(MAX_CELLS)) begin
                        r_sing <= 1'b1;
                        r_st <= s_axis_tlast ? ST_WR : ST_IDLE;
                    end else r_st <= ST_DIAG;
                end
                ST_DIAG: begin
                    r_acc <= w_sa[W-1:0]; r_sing <= r_sing | w_sa[W];
                    r_ma <= r_w; r_mb <= r_prev_o; r_mphase <= 1'b0;
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    if (!r_mphase) begin
                        // Product of w and prev ratio has landed: den = diag - w * ratio.
                        r_den <= w_sd[W-1:0]; r_sing <= r_sing | w_sd[W];
                        r_acc <= r_s;
                        r_mphase <= 1'b1;
                    end else begin
                        // Product of w and prev offset has landed: num = w * offset + s.
                        r_num <= w_sb[W-1:0]; r_sing <= r_sing | w_sb[W];
                        r_mphase <= 1'b0;
                        r_st <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    if (r_den == '0) r_sing <= 1'b1;
                    r_st <= ST_DR;
                end
                ST_DR: if (w_ddone) begin
                    r_ratio <= (r_den == '0) ? ((r_e == '0) ? '0 : (r_e[W-1] ? S32_MIN : S32_MAX))
                                             : w_quo;
                    r_sing <= r_sing | (w_dsat && r_den != '0);
                    r_st <= ST_DO;
                end
                ST_DO: if (w_ddone) begin
                    r_num <= (r_den == '0) ? ((r_num == '0) ? '0 :
                             (r_num[W-1] ? S32_MIN : S32_MAX)) : w_quo;
                    r_sing <= r_sing | (w_dsat && r_den != '0);
                    r_st <= ST_STORE;
                end
                ST_STORE: begin
                    r_prev_r <= r_ratio; r_prev_o <= r_num;
                    r_cnt <= r_cnt + 1'b1;
                    r_idx <= r_cnt;
                    r_st <= r_last ? ST_BRD : ST_IDLE;
                end
                ST_WR: begin
                    r_idx <= r_cnt - 1'b1;
                    r_st <= ST_BRD;
                end
                ST_BRD: r_st <= ST_BMUL;
                ST_BMUL: begin
                    r_ma <= r_rd_r; r_mb <= r_x; r_acc <= r_rd_o;
                    r_st <= ST_BADD;
                end
                ST_BADD: if (r_mphase) begin
                    r_x <= w_sb[W-1:0]; r_sing <= r_sing | w_sb[W];
                    r_mphase <= 1'b0;
                    if (r_idx == '0) begin
                        // Sweep done; emit from the last cell down.
                        r_idx <= r_cnt - 1'b1; r_st <= ST_ERD;
                    end else begin
                        r_idx <= r_idx - 1'b1; r_st <= ST_BRD;
                    end
                end else r_mphase <= 1'b1;
                ST_ERD: r_st <= ST_OUT;
                ST_OUT: if (m_axis_tready) begin
                    if (r_idx == '0) begin
                        r_st <= ST_IDLE; r_cnt <= '0; r_sing <= 1'b0;
                        r_prev_r <= '0; r_prev_o <= '0;
                    end else begin
                        r_idx <= r_idx - 1'b1; r_st <= ST_ERD;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "accept while emitting")
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_CELLS), "cell count overflow")
    `ASSERT_NEXT(a_end_clear, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        r_cnt == '0, "count not cleared at run end")
endmodule

// ===== design/tdma_div.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle.
module tdma_div
    import tdma_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_ctl             i_ctl,
    input  logic signed [W-1:0]  i_num,
    input  logic signed [W-1:0]  i_den,
    output logic                 o_done,
    output logic signed [W-1:0]  o_quo,
    output logic                 o_sat
);
    localparam int NB = W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_dvd, n_dvd;
    logic [W:0]    r_rem, n_rem;
    logic [W:0]    r_dsr;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic [W+1:0]  w_trial;
    logic [W:0]    w_shift;
    logic [NB:0]   w_mag;
    logic signed [65:0] w_sq;
    logic [W:0]    w_st;

    always_comb begin
        w_shift = {r_rem[W-1:0], r_dvd[NB-1]};
        w_trial = {1'b0, w_shift} - {1'b0, r_dsr};
        n_dvd = {r_dvd[NB-2:0], ~w_trial[W+1]};
        n_rem = w_trial[W+1] ? w_shift : w_trial[W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= CW'(NB);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= NB'({(W+1)'(i_num[W-1] ? -{i_num[W-1], i_num} : {i_num[W-1], i_num})})
                     << FRAC_BITS;
            r_dsr <= i_den[W-1] ? -{i_den[W-1], i_den} : {i_den[W-1], i_den};
            r_neg <= i_num[W-1] ^ i_den[W-1];
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_run && (r_cnt == CW'(1));
    always_comb begin
        w_mag = {1'b0, n_dvd};
        w_sq = r_neg ? -66'(w_mag) : 66'(w_mag);
        w_st = sat32(w_sq);
        o_quo = w_st[W-1:0];
        o_sat = w_st[W];
    end
endmodule
